[rtl/coalescing_region_reservation_table_unit_macros.svh]
// assertion macros for the region reservation table checker
// no dependencies; expects clk and rst in the scope of use
`ifndef COALESCING_REGION_RESERVATION_TABLE_UNIT_MACROS_SVH
`define COALESCING_REGION_RESERVATION_TABLE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CRRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crrt assertion failed");

// next-cycle implication, disabled in reset
`define CRRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crrt assertion failed");

`endif

[rtl/crrt_pkg.sv]
// shared types and constants of the region reservation table
// no dependencies
package crrt_pkg;

  localparam int ENTRIES   = 128;
  localparam int ADDR_BITS = 32;
  localparam int TYPE_BITS = 4;
  localparam int IDX_W     = $clog2(ENTRIES);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [TYPE_BITS-1:0] kind_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic [1:0] {
    CMD_RESERVE = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  typedef struct packed {
    logic  valid;
    addr_t first;
    addr_t last;
    kind_t kind;
  } entry_t;

  typedef struct packed {
    logic [1:0] cmd;
    addr_t      range_start;
    addr_t      range_end;
    kind_t      region_type;
  } req_item_t;

  typedef struct packed {
    logic [1:0] status;
    addr_t      clipped_start;
    addr_t      clipped_end;
  } rsp_item_t;

endpackage

[rtl/coalescing_region_reservation_table_unit.sv]
// top level of the coalescing region reservation table
// depends on crrt_pkg and crrt_cell
//
// The table lives in a ring of ENTRIES cells that rotates by one entry per
// cycle while a command runs; the head cell is inspected and rewritten on
// its way back into the tail. One item is handled at a time. A reserve that
// changes the table takes two full turns of the ring (a scan for overlap,
// neighbors and a free slot, then an update turn); a reserve that is
// rejected for overlap or a full table, a query and a clear take one turn. A
// reserve or query whose start is not below its end, or an unused command,
// skips the ring and goes straight to the result. No clearing pass is needed
// after reset: only the valid bits are reset. The next item is taken as soon
// as the result sits in the output register.
module coalescing_region_reservation_table_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  crrt_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output crrt_pkg::rsp_item_t rsp
);
  import crrt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_APPLY  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;

  // ring of cells
  entry_t cell_q [ENTRIES];
  entry_t head, head_next;
  logic   shift;

  assign shift = (state == S_SCAN) || (state == S_APPLY);
  assign head  = cell_q[0];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t d;
    if (i == ENTRIES - 1) begin : g_tail
      assign d = head_next;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    crrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d),
      .q     (cell_q[i])
    );
  end

  // current item
  req_item_t cur;
  idx_t      cnt;
  logic      accept;
  logic      pass_end;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign pass_end  = (cnt == idx_t'(ENTRIES - 1));

  // scan results
  logic  any_ovl, have_left, have_right, have_free, placed;
  addr_t right_last;
  logic  best_found;
  addr_t best_first, best_last;

  // result waiting for the output register
  status_t res_status;
  addr_t   res_cs, res_ce;

  // head inspection
  logic k_match, ovl, is_left, is_right;

  always_comb begin
    k_match  = head.valid && (head.kind == cur.region_type);
    ovl      = head.valid && (head.first <= cur.range_end) &&
               (cur.range_start <= head.last);
    is_left  = k_match && (cur.range_start != '0) &&
               (head.last == cur.range_start - addr_t'(1));
    is_right = k_match && (cur.range_end != '1) &&
               (head.first == cur.range_end + addr_t'(1));
  end

  // rewrite of the head on its way to the tail
  always_comb begin
    head_next = head;
    if (state == S_SCAN) begin
      if (cur.cmd == CMD_CLEAR && k_match) begin
        head_next.valid = 1'b0;
      end
    end else if (state == S_APPLY) begin
      if (have_left && have_right) begin
        // both neighbors: left grows to the right entry's end
        if (is_left) begin
          head_next.last = right_last;
        end
        if (is_right) begin
          head_next.valid = 1'b0;
        end
      end else if (have_left) begin
        if (is_left) begin
          head_next.last = cur.range_end;
        end
      end else if (have_right) begin
        if (is_right) begin
          head_next.first = cur.range_start;
        end
      end else if (!head.valid && !placed) begin
        head_next.valid = 1'b1;
        head_next.first = cur.range_start;
        head_next.last  = cur.range_end;
        head_next.kind  = cur.region_type;
      end
    end
  end

  // state machine
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) begin
                  if ((req.cmd == CMD_CLEAR) ||
                      ((req.cmd == CMD_RESERVE || req.cmd == CMD_QUERY) &&
                       req.range_start < req.range_end)) begin
                    state_next = S_SCAN;
                  end else begin
                    state_next = S_DONE;
                  end
                end
      S_SCAN:   if (pass_end) begin
                  state_next = S_DECIDE;
                end
      S_DECIDE: begin
                  if (cur.cmd == CMD_RESERVE && !any_ovl &&
                      (have_left || have_right || have_free)) begin
                    state_next = S_APPLY;
                  end else begin
                    state_next = S_DONE;
                  end
                end
      S_APPLY:  if (pass_end) begin
                  state_next = S_DONE;
                end
      S_DONE:   if (!rsp_valid || !rsp_stall) begin
                  state_next = S_IDLE;
                end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur        <= req;
      cnt        <= '0;
      any_ovl    <= 1'b0;
      have_left  <= 1'b0;
      have_right <= 1'b0;
      have_free  <= 1'b0;
      placed     <= 1'b0;
      best_found <= 1'b0;
      res_status <= ST_BAD;
      res_cs     <= '0;
      res_ce     <= '0;
    end
    if (shift) begin
      cnt <= pass_end ? '0 : cnt + idx_t'(1);
    end
    if (state == S_SCAN) begin
      if (ovl) begin
        any_ovl <= 1'b1;
        // lowest start among overlapping entries
        if (!best_found || head.first < best_first) begin
          best_found <= 1'b1;
          best_first <= head.first;
          best_last  <= head.last;
        end
      end
      if (is_left) begin
        have_left <= 1'b1;
      end
      if (is_right) begin
        have_right <= 1'b1;
        right_last <= head.last;
      end
      if (!head.valid) begin
        have_free <= 1'b1;
      end
    end
    if (state == S_APPLY && !head.valid) begin
      placed <= 1'b1;
    end
    if (state == S_DECIDE) begin
      res_cs <= '0;
      res_ce <= '0;
      case (cur.cmd)
        CMD_RESERVE: begin
          if (any_ovl) begin
            res_status <= ST_MISS;
          end else if (!have_left && !have_right && !have_free) begin
            res_status <= ST_FULL;
          end else begin
            res_status <= ST_OK;
          end
        end
        CMD_QUERY: begin
          if (best_found) begin
            res_status <= ST_OK;
            res_cs <= (best_first > cur.range_start) ? best_first : cur.range_start;
            res_ce <= (best_last < cur.range_end) ? best_last : cur.range_end;
          end else begin
            res_status <= ST_MISS;
          end
        end
        CMD_CLEAR: res_status <= ST_OK;
        default:   res_status <= ST_BAD;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp.status        <= res_status;
      rsp.clipped_start <= res_cs;
      rsp.clipped_end   <= res_ce;
    end
  end

endmodule

[rtl/crrt_cell.sv]
// one table cell: holds one entry, loads its neighbor's entry on shift
// depends on crrt_pkg
module crrt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  crrt_pkg::entry_t d,
  output crrt_pkg::entry_t q
);
  import crrt_pkg::*;

  // only the valid bit is reset; the rest is don't-care while invalid
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (shift) begin
      q.valid <= d.valid;
    end
    if (shift) begin
      q.first <= d.first;
      q.last  <= d.last;
      q.kind  <= d.kind;
    end
  end

endmodule

[rtl/crrt_checker.sv]
// port-level checker for the region reservation table, bound to the top level
// depends on crrt_pkg and the assertion macro header
`include "coalescing_region_reservation_table_unit_macros.svh"

module crrt_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input crrt_pkg::req_item_t req,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input crrt_pkg::rsp_item_t rsp
);
  import crrt_pkg::*;

  // a stalled result holds
  `CRRT_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // one item at a time: busy right after an accept
  `CRRT_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

  // clipped fields are zero unless status is ok
  `CRRT_ASSERT_IMP(a_clip_zero, rsp_valid && rsp.status != ST_OK,
                   rsp.clipped_start == '0 && rsp.clipped_end == '0)

  // a clipped range is never reversed
  `CRRT_ASSERT_IMP(a_clip_order, rsp_valid, rsp.clipped_start <= rsp.clipped_end)

endmodule

bind coalescing_region_reservation_table_unit crrt_checker u_crrt_checker (.*);
